// ===== hdl/abec_pkg.sv =====
`default_nettype none

package abec_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(DATA_W);
  localparam int unsigned OUT_W     = 104;  // 100 payload bits padded to bytes

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_NO_OP    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/ascii_binary_expression_calc_core.sv =====
// Non-final byte: accepted while idle; the block stays ready for the next byte.
// Final byte: no-operator, bad-input and divide-by-zero results go straight to S_OUT;
// add/subtract run S_CALC, multiply S_MUL (32 shift-add steps), divide S_PREP, then
// S_DIV (32 restoring steps) and S_FIX (sign fix); all but S_PREP share a 33-bit adder.
// The block is busy until the result is loaded into the output register.
// Reset (rst_ni low, async) clears the parser, the sequencer and output valid.
`default_nettype none

module ascii_binary_expression_calc_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [7:0]                 s_axis_tdata_i,   // [7:0] char_in
  input  wire logic                       s_axis_tlast_i,   // final_byte
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // [1:0] status, [33:2] left_operand, [35:34] op_code,
  // [67:36] right_operand, [99:68] value, [103:100] zero
  output logic [abec_pkg::OUT_W-1:0]      m_axis_tdata_o
);

  import abec_pkg::*;

  // ---------------------------------------------------------------------------
  // Parser state (one expression)
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] accum_q, accum_d;
  logic              negative_q, negative_d;
  logic              operand_start_q, operand_start_d;
  logic              op_seen_q, op_seen_d;
  op_e               held_op_q, held_op_d;
  logic [DATA_W-1:0] held_first_q, held_first_d;
  logic              bad_input_q, bad_input_d;

  // ---------------------------------------------------------------------------
  // Sequencer and shared-unit working registers
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  status_e           status_q, status_d;
  op_e               opc_q, opc_d;
  logic [DATA_W-1:0] lhs_q, lhs_d;
  logic [DATA_W-1:0] rhs_q, rhs_d;
  logic [DATA_W-1:0] val_q, val_d;     // result; product accumulator in multiply
  logic [DATA_W-1:0] wa_q, wa_d;       // multiplicand / partial remainder
  logic [DATA_W-1:0] wb_q, wb_d;       // multiplier / dividend shifting to quotient
  logic [DATA_W-1:0] dvs_q, dvs_d;     // divisor magnitude
  logic              qneg_q, qneg_d;

  // Output register
  logic              m_valid_q, m_valid_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              is_digit;
  logic              is_op;
  op_e               char_op;
  logic [7:0]        digit;
  logic [DATA_W-1:0] operand_now;     // signed view of the operand being parsed

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign is_digit        = (s_axis_tdata_i >= CHAR_ZERO) && (s_axis_tdata_i <= CHAR_NINE);
  assign digit           = s_axis_tdata_i - CHAR_ZERO;
  assign operand_now     = negative_q ? (DATA_W'(0) - accum_q) : accum_q;

  always_comb begin
    is_op   = 1'b1;
    char_op = OP_ADD;
    case (s_axis_tdata_i)
      CHAR_PLUS:  char_op = OP_ADD;
      CHAR_MINUS: char_op = OP_SUB;
      CHAR_STAR:  char_op = OP_MUL;
      CHAR_SLASH: char_op = OP_DIV;
      default:    is_op   = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared 33-bit add/subtract unit
  // ---------------------------------------------------------------------------
  logic [DATA_W:0]   alu_a, alu_b;
  logic              alu_sub;
  logic [DATA_W+1:0] alu_res;         // carry out on top
  logic [DATA_W:0]   rem_sh;

  assign rem_sh  = {wa_q, wb_q[DATA_W-1]};
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{(DATA_W+1){1'b0}}, alu_sub};

  always_comb begin
    alu_a   = {1'b0, lhs_q};
    alu_b   = {1'b0, rhs_q};
    alu_sub = 1'b0;
    case (state_q)
      S_CALC: begin
        alu_sub = (opc_q == OP_SUB);
      end
      S_MUL: begin
        alu_a = {1'b0, val_q};
        alu_b = {1'b0, wa_q};
      end
      S_DIV: begin
        alu_a   = rem_sh;
        alu_b   = {1'b0, dvs_q};
        alu_sub = 1'b1;
      end
      S_FIX: begin
        alu_a   = '0;
        alu_b   = {1'b0, wb_q};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic last_step;
  assign last_step = (cnt_q == CNT_W'(DATA_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tlast_i) begin
          if (bad_input_q || !op_seen_q) begin
            state_d = S_OUT;
          end else begin
            case (held_op_q)
              OP_ADD, OP_SUB: state_d = S_CALC;
              OP_MUL:         state_d = S_MUL;
              default:        state_d = (operand_now == '0) ? S_OUT : S_PREP;
            endcase
          end
        end
      end
      S_CALC:  state_d = S_OUT;
      S_MUL:   state_d = last_step ? S_OUT : S_MUL;
      S_PREP:  state_d = S_DIV;
      S_DIV:   state_d = last_step ? S_FIX : S_DIV;
      S_FIX:   state_d = S_OUT;
      S_OUT:   state_d = (!m_valid_q || m_axis_tready_i) ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    accum_d         = accum_q;
    negative_d      = negative_q;
    operand_start_d = operand_start_q;
    op_seen_d       = op_seen_q;
    held_op_d       = held_op_q;
    held_first_d    = held_first_q;
    bad_input_d     = bad_input_q;
    cnt_d           = cnt_q;
    status_d        = status_q;
    opc_d           = opc_q;
    lhs_d           = lhs_q;
    rhs_d           = rhs_q;
    val_d           = val_q;
    wa_d            = wa_q;
    wb_d            = wb_q;
    dvs_d           = dvs_q;
    qneg_d          = qneg_q;
    m_valid_d       = m_valid_q & ~m_axis_tready_i;
    m_data_d        = m_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc && !s_axis_tlast_i && !bad_input_q) begin
          if (is_digit) begin
            // accum * 10 + digit, wrapping
            accum_d = {accum_q[DATA_W-4:0], 3'b000} + {accum_q[DATA_W-2:0], 1'b0}
                    + {{(DATA_W-8){1'b0}}, digit};
            operand_start_d = 1'b0;
          end else if (!is_op) begin
            bad_input_d = 1'b1;
          end else if (operand_start_q && (char_op == OP_SUB)) begin
            negative_d      = 1'b1;
            operand_start_d = 1'b0;
          end else if (!op_seen_q) begin
            held_op_d       = char_op;
            op_seen_d       = 1'b1;
            held_first_d    = operand_now;
            accum_d         = '0;
            negative_d      = 1'b0;
            operand_start_d = 1'b1;
          end else begin
            bad_input_d = 1'b1;     // second operator
          end
        end else if (in_acc && s_axis_tlast_i) begin
          // capture the expression, then clear the parser
          cnt_d  = '0;
          val_d  = '0;
          status_d = ST_OK;
          lhs_d  = held_first_q;
          opc_d  = held_op_q;
          rhs_d  = operand_now;
          wa_d   = held_first_q;
          wb_d   = operand_now;
          if (bad_input_q) begin
            status_d = ST_BAD;
            lhs_d    = '0;
            opc_d    = OP_ADD;
            rhs_d    = '0;
          end else if (!op_seen_q) begin
            status_d = ST_NO_OP;
            lhs_d    = '0;
            opc_d    = OP_ADD;
          end else if ((held_op_q == OP_DIV) && (operand_now == '0)) begin
            status_d = ST_DIV_ZERO;
          end
          accum_d         = '0;
          negative_d      = 1'b0;
          operand_start_d = 1'b1;
          op_seen_d       = 1'b0;
          held_op_d       = OP_ADD;
          held_first_d    = '0;
          bad_input_d     = 1'b0;
        end
      end
      S_CALC: begin
        val_d = alu_res[DATA_W-1:0];
      end
      S_MUL: begin
        // shift-add: one multiplier bit per cycle
        if (wb_q[0]) begin
          val_d = alu_res[DATA_W-1:0];
        end
        wa_d  = {wa_q[DATA_W-2:0], 1'b0};
        wb_d  = {1'b0, wb_q[DATA_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_PREP: begin
        wa_d   = '0;
        wb_d   = lhs_q[DATA_W-1] ? (DATA_W'(0) - lhs_q) : lhs_q;
        dvs_d  = rhs_q[DATA_W-1] ? (DATA_W'(0) - rhs_q) : rhs_q;
        qneg_d = lhs_q[DATA_W-1] ^ rhs_q[DATA_W-1];
        cnt_d  = '0;
      end
      S_DIV: begin
        // restoring step: carry out set means no borrow
        wa_d  = alu_res[DATA_W+1] ? alu_res[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        wb_d  = {wb_q[DATA_W-2:0], alu_res[DATA_W+1]};
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_FIX: begin
        val_d = qneg_q ? alu_res[DATA_W-1:0] : wb_q;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0000, val_q, rhs_q, opc_q, lhs_q, status_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      accum_q         <= '0;
      negative_q      <= 1'b0;
      operand_start_q <= 1'b1;
      op_seen_q       <= 1'b0;
      held_op_q       <= OP_ADD;
      held_first_q    <= '0;
      bad_input_q     <= 1'b0;
      cnt_q           <= '0;
      m_valid_q       <= 1'b0;
    end else begin
      state_q         <= state_d;
      accum_q         <= accum_d;
      negative_q      <= negative_d;
      operand_start_q <= operand_start_d;
      op_seen_q       <= op_seen_d;
      held_op_q       <= held_op_d;
      held_first_q    <= held_first_d;
      bad_input_q     <= bad_input_d;
      cnt_q           <= cnt_d;
      m_valid_q       <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    opc_q    <= opc_d;
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
    val_q    <= val_d;
    wa_q     <= wa_d;
    wb_q     <= wb_d;
    dvs_q    <= dvs_d;
    qneg_q   <= qneg_d;
    m_data_q <= m_data_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // parser is back at its reset state after the final byte
  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (accum_q == '0) && !op_seen_q && operand_start_q
                                   && !bad_input_q && !negative_q)
    else $error("parser state not cleared after final byte");

  // a new word appears only from the output state
  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT))
    else $error("output loaded outside output state");

  // error results carry a zero value
  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_data_q[1:0] != ST_OK)) |-> (m_data_q[99:68] == '0))
    else $error("nonzero value with error status");

  // divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dvs_q != '0))
    else $error("divide step with zero divisor");

endmodule

`default_nettype wire

// ===== dv/calc_result_checker.sv =====
module calc_result_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [7:0]                 in_data_i,    // [7:0] char_in
  input  wire logic                       in_last_i,    // final_byte
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [abec_pkg::OUT_W-1:0] out_data_i,
  output int                              fails_o,
  output int                              pending_o,
  output int                              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import abec_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [31:0] left;
    op_e         op;
    logic [31:0] right;
    logic [31:0] value;
  } calc_answer_t;

  // parser state of the expression in flight
  logic [31:0]  acc_q;
  logic [31:0]  first_q;
  bit           neg_q;
  bit           at_start_q;
  bit           have_op_q;
  bit           broken_q;
  op_e          pend_op_q;

  calc_answer_t awaited_answers[$];
  calc_answer_t want;

  function automatic bit decode_op(input logic [7:0] c, output op_e kind);
    decode_op = 1'b1;
    kind = OP_ADD;
    case (c)
      CHAR_PLUS:  kind = OP_ADD;
      CHAR_MINUS: kind = OP_SUB;
      CHAR_STAR:  kind = OP_MUL;
      CHAR_SLASH: kind = OP_DIV;
      default:    decode_op = 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] operand_now();
    return neg_q ? 32'd0 - acc_q : acc_q;
  endfunction

  // signed divide, rounds toward zero; most negative / -1 wraps to itself
  function automatic logic [31:0] div_toward_zero(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn;
    logic [31:0] md;
    logic [31:0] q;
    mn = n[31] ? 32'd0 - n : n;
    md = d[31] ? 32'd0 - d : d;
    q  = mn / md;
    return (n[31] ^ d[31]) ? 32'd0 - q : q;
  endfunction

  task automatic clear_parse();
    acc_q      = '0;
    first_q    = '0;
    neg_q      = 1'b0;
    at_start_q = 1'b1;
    have_op_q  = 1'b0;
    broken_q   = 1'b0;
    pend_op_q  = OP_ADD;
  endtask

  task automatic take_byte(input logic [7:0] c, input logic fin);
    op_e          kind;
    calc_answer_t ans;
    if (!fin) begin
      if (!broken_q) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          acc_q      = acc_q * 32'd10 + 32'(c - CHAR_ZERO);
          at_start_q = 1'b0;
        end else if (!decode_op(c, kind)) begin
          broken_q = 1'b1;
        end else if (at_start_q && c == CHAR_MINUS) begin
          neg_q      = 1'b1;
          at_start_q = 1'b0;
        end else if (!have_op_q) begin
          pend_op_q  = kind;
          have_op_q  = 1'b1;
          first_q    = operand_now();
          acc_q      = '0;
          neg_q      = 1'b0;
          at_start_q = 1'b1;
        end else begin
          broken_q = 1'b1;
        end
      end
    end else begin
      ans = '0;
      ans.status = ST_OK;
      ans.op = OP_ADD;
      if (broken_q) begin
        ans.status = ST_BAD;
      end else if (!have_op_q) begin
        ans.status = ST_NO_OP;
        ans.right  = operand_now();
      end else begin
        ans.left  = first_q;
        ans.op    = pend_op_q;
        ans.right = operand_now();
        case (pend_op_q)
          OP_ADD: ans.value = first_q + ans.right;
          OP_SUB: ans.value = first_q - ans.right;
          OP_MUL: ans.value = first_q * ans.right;
          default: begin
            if (ans.right == '0) ans.status = ST_DIV_ZERO;
            else ans.value = div_toward_zero(first_q, ans.right);
          end
        endcase
      end
      awaited_answers.push_back(ans);
      clear_parse();
    end
  endtask

  function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                      input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      awaited_answers.delete();
      fails_o = 0;
      checked_o = 0;
      pending_o <= 0;
    end else begin
      // result side first: a result can never belong to a word taken at the same edge
      if (out_valid_i === 1'b1 && out_ready_i === 1'b1) begin
        if (awaited_answers.size() == 0) begin
          $error("result word with no expression pending: %h", out_data_i);
          fails_o++;
        end else begin
          want = awaited_answers.pop_front();
          check_field("status", want.status, out_data_i[1:0]);
          check_field("left_operand", $signed(want.left), $signed(out_data_i[33:2]));
          check_field("op_code", want.op, out_data_i[35:34]);
          check_field("right_operand", $signed(want.right), $signed(out_data_i[67:36]));
          check_field("value", $signed(want.value), $signed(out_data_i[99:68]));
          check_field("pad", 64'd0, out_data_i[OUT_W-1:100]);
          checked_o++;
        end
      end
      if (in_valid_i === 1'b1 && in_ready_i === 1'b1) take_byte(in_data_i, in_last_i);
      pending_o <= awaited_answers.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abec_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  wire              s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i;   // [7:0] char_in
  logic             s_axis_tlast_i;   // final_byte
  wire              m_axis_tvalid_o;
  logic             m_axis_tready_i;
  // [1:0] status, [33:2] left_operand, [35:34] op_code,
  // [67:36] right_operand, [99:68] value, [103:100] zero
  wire  [OUT_W-1:0] m_axis_tdata_o;

  int   fails;
  int   pending;
  int   checked;
  int   words_sent;
  int   exprs_sent;
  bit   calm;           // end of run: no stalls on either side
  logic [7:0] expr_q[$];  // bytes of the expression being built

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ascii_binary_expression_calc_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  calc_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_i (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_i  (m_axis_tdata_o),
    .fails_o     (fails),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // --- sender side ---

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [7:0] c, input logic fin);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    words_sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Hold off until every result in flight has been seen by the checker.
  // pending is registered in the checker, so the first edge after the last word is always waited.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Sends the built bytes, then the terminating word with junk in char_in.
  task automatic play_expr();
    foreach (expr_q[i]) begin
      maybe_gap();
      send_word(expr_q[i], 1'b0);
    end
    maybe_gap();
    send_word(8'($urandom_range(0, 255)), 1'b1);
    expr_q.delete();
    exprs_sent++;
  endtask

  // --- expression building ---

  task automatic add_text(input string s);
    foreach (s[i]) expr_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] op_char(input int unsigned k);
    case (k)
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      default: return CHAR_SLASH;
    endcase
  endfunction

  // Magnitudes lean on the wrap points of a 32-bit accumulator.
  function automatic logic [63:0] pick_mag();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return 64'($urandom_range(0, 9));
      2:       return 64'($urandom_range(0, 999));
      3:       return 64'($urandom);
      4:       return 64'd2147483648;
      5:       return 64'd2147483647;
      6:       return 64'd4294967295;
      default: return {$urandom, $urandom} % 64'd1000000000000;
    endcase
  endfunction

  // Optional leading minus, then digits; empty digits now and then.
  task automatic add_operand();
    if ($urandom_range(0, 3) == 0) expr_q.push_back(CHAR_MINUS);
    if ($urandom_range(0, 9) != 0) add_text($sformatf("%0d", pick_mag()));
  endtask

  // --- receiver side: bursts of back-pressure between ready stretches ---
  initial begin
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Generous cap on the run time; a correct run ends well before it.
  initial begin
    #5000000;
    $display("ascii_binary_expression_calc_core verification failed");
    $finish;
  end

  initial begin
    int unsigned roll;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    calm            = 1'b0;
    words_sent      = 0;
    exprs_sent      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: leading operator (0+0)
    add_text("+");
    play_expr();
    // repeated minus: second '-' is the operator, 0-5
    add_text("--5");
    play_expr();
    add_text("9/0");
    play_expr();
    add_text("6*7");
    play_expr();
    // bad bytes at both char extremes
    add_text("7");
    expr_q.push_back(8'hFF);
    play_expr();
    expr_q.push_back(8'h00);
    play_expr();
    // second operator
    add_text("*/");
    play_expr();
    // no operator at all
    add_text("42");
    play_expr();

    wait_drained();

    // random: mostly well-formed, some operator-less, malformed and pure noise
    while (words_sent < 650) begin
      if (words_sent >= 560 && !calm) calm <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        add_text("-2147483648/-1");
      end else if (roll < 70) begin
        add_operand();
        expr_q.push_back(op_char($urandom_range(0, 3)));
        add_operand();
      end else if (roll < 80) begin
        add_operand();
      end else if (roll < 92) begin
        add_operand();
        if ($urandom_range(0, 1) == 0) expr_q.push_back(8'($urandom_range(0, 255)));
        else expr_q.push_back(op_char($urandom_range(0, 3)));
        expr_q.push_back(op_char($urandom_range(0, 3)));
        add_operand();
      end else begin
        repeat ($urandom_range(1, 5)) expr_q.push_back(8'($urandom_range(0, 255)));
      end
      play_expr();
      if (!calm && $urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    // catch any stray result after the drain
    repeat (60) @(posedge clk_i);

    $display("Run covered %0d words in %0d expressions, %0d results compared.",
             words_sent, exprs_sent, checked);
    $display("Mix: directed corner expressions, then random well-formed, malformed and noise input.");
    if (fails == 0) begin
      $display("ascii_binary_expression_calc_core verification clean");
    end else begin
      $display("ascii_binary_expression_calc_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/abec_pkg.sv
hdl/ascii_binary_expression_calc_core.sv
dv/calc_result_checker.sv
dv/tb_top.sv
